@@ sv/binary_to_roman_numeral_assert.svh @@
`ifndef BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH
`define BINARY_TO_ROMAN_NUMERAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define B2R_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define B2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/b2r_pkg.sv @@
package b2r_pkg;

   typedef logic [2:0] letter_type;

   localparam letter_type LTR_I = 3'd0;
   localparam letter_type LTR_V = 3'd1;
   localparam letter_type LTR_X = 3'd2;
   localparam letter_type LTR_L = 3'd3;
   localparam letter_type LTR_C = 3'd4;
   localparam letter_type LTR_D = 3'd5;
   localparam letter_type LTR_M = 3'd6;

   localparam logic [11:0] MAX_VALUE = 12'd3999;
   localparam int          LINE_LEN  = 16;

   typedef struct packed {
      logic [1:0] th;
      logic [3:0] hu;
      logic [3:0] te;
      logic [3:0] un;
      logic       zero;
      logic       oor;
   } b2r_digits_type;

   typedef struct packed {
      letter_type [3:0] ltr;
      logic [2:0]       len;
   } b2r_word_type;

   typedef struct packed {
      letter_type [7:0] ltr;
      logic [3:0]       len;
   } b2r_half_type;

   typedef struct packed {
      b2r_half_type hi;
      b2r_half_type lo;
      logic         zero;
      logic         oor;
   } b2r_letters_type;

   typedef letter_type [LINE_LEN-1:0] b2r_line_type;

   // Letters of one decimal digit, first letter at index 0.
   function automatic b2r_word_type digit_word(input logic [3:0] d, input letter_type one,
                                               input letter_type five, input letter_type ten);
      b2r_word_type w;
      w.ltr = {one, one, one, one};
      w.len = 3'd0;
      case (d)
         4'd0: w.len = 3'd0;
         4'd1: w.len = 3'd1;
         4'd2: w.len = 3'd2;
         4'd3: w.len = 3'd3;
         4'd4: begin
            w.ltr[1] = five;
            w.len    = 3'd2;
         end
         4'd5: begin
            w.ltr[0] = five;
            w.len    = 3'd1;
         end
         4'd6: begin
            w.ltr[0] = five;
            w.len    = 3'd2;
         end
         4'd7: begin
            w.ltr[0] = five;
            w.len    = 3'd3;
         end
         4'd8: begin
            w.ltr[0] = five;
            w.len    = 3'd4;
         end
         4'd9: begin
            w.ltr[1] = ten;
            w.len    = 3'd2;
         end
         default: w.len = 3'd0;
      endcase
      return w;
   endfunction

   function automatic b2r_half_type cat_words(input b2r_word_type a, input b2r_word_type b);
      b2r_half_type r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < a.len) r.ltr[i] = a.ltr[i];
      end
      for (int k = 0; k <= 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            if (a.len == 3'(k)) r.ltr[j+k] = b.ltr[j];
         end
      end
      r.len = 4'(a.len) + 4'(b.len);
      return r;
   endfunction

   function automatic b2r_line_type cat_halves(input b2r_half_type a, input b2r_half_type b);
      b2r_line_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < a.len) r[i] = a.ltr[i];
      end
      for (int k = 0; k <= 8; k++) begin
         for (int j = 0; j < 8; j++) begin
            if (a.len == 4'(k)) r[j+k] = b.ltr[j];
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] letter_ascii(input letter_type l);
      logic [7:0] c;
      case (l)
         LTR_I:   c = 8'h49;
         LTR_V:   c = 8'h56;
         LTR_X:   c = 8'h58;
         LTR_L:   c = 8'h4C;
         LTR_C:   c = 8'h43;
         LTR_D:   c = 8'h44;
         LTR_M:   c = 8'h4D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ sv/b2r_digits.sv @@
module b2r_digits
   import b2r_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [11:0]    in_value,
   output logic           out_valid,
   input  logic           out_ready,
   output b2r_digits_type out_digits
);

   logic           s1_vld_ff, s1_vld_in, s1_ready;
   logic [1:0]     s1_th_ff, s1_th_in;
   logic [9:0]     s1_rem_ff, s1_rem_in;
   logic           s1_zero_ff, s1_zero_in;
   logic           s1_oor_ff, s1_oor_in;

   logic           s2_vld_ff, s2_vld_in, s2_ready;
   logic [1:0]     s2_th_ff;
   logic [3:0]     s2_hu_ff, s2_hu_in;
   logic [6:0]     s2_rem_ff, s2_rem_in;
   logic           s2_zero_ff, s2_oor_ff;

   logic           s3_vld_ff, s3_vld_in, s3_ready;
   b2r_digits_type s3_dig_ff, s3_dig_in;

   assign s3_ready = !s3_vld_ff || out_ready;
   assign s2_ready = !s2_vld_ff || s3_ready;
   assign s1_ready = !s1_vld_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_vld_in  = s1_ready ? in_valid : s1_vld_ff;
      s1_oor_in  = in_value > MAX_VALUE;
      s1_zero_in = in_value == 12'd0;
      s1_th_in   = 2'd0;
      s1_rem_in  = in_value[9:0];
      if (in_value >= 12'd3000) begin
         s1_th_in  = 2'd3;
         s1_rem_in = 10'(in_value - 12'd3000);
      end else if (in_value >= 12'd2000) begin
         s1_th_in  = 2'd2;
         s1_rem_in = 10'(in_value - 12'd2000);
      end else if (in_value >= 12'd1000) begin
         s1_th_in  = 2'd1;
         s1_rem_in = 10'(in_value - 12'd1000);
      end
   end

   always_comb begin
      s2_vld_in = s2_ready ? s1_vld_ff : s2_vld_ff;
      s2_hu_in  = 4'd0;
      s2_rem_in = s1_rem_ff[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            s2_hu_in  = 4'(k);
            s2_rem_in = 7'(s1_rem_ff - 10'(k * 100));
         end
      end
   end

   always_comb begin
      s3_vld_in      = s3_ready ? s2_vld_ff : s3_vld_ff;
      s3_dig_in.th   = s2_th_ff;
      s3_dig_in.hu   = s2_hu_ff;
      s3_dig_in.zero = s2_zero_ff;
      s3_dig_in.oor  = s2_oor_ff;
      s3_dig_in.te   = 4'd0;
      s3_dig_in.un   = s2_rem_ff[3:0];
      for (int k = 1; k <= 9; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            s3_dig_in.te = 4'(k);
            s3_dig_in.un = 4'(s2_rem_ff - 7'(k * 10));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_th_ff   <= s1_th_in;
         s1_rem_ff  <= s1_rem_in;
         s1_zero_ff <= s1_zero_in;
         s1_oor_ff  <= s1_oor_in;
      end
      if (s2_ready && s1_vld_ff) begin
         s2_th_ff   <= s1_th_ff;
         s2_hu_ff   <= s2_hu_in;
         s2_rem_ff  <= s2_rem_in;
         s2_zero_ff <= s1_zero_ff;
         s2_oor_ff  <= s1_oor_ff;
      end
      if (s3_ready && s2_vld_ff) begin
         s3_dig_ff <= s3_dig_in;
      end
   end

   assign out_valid  = s3_vld_ff;
   assign out_digits = s3_dig_ff;

endmodule

@@ sv/b2r_letters.sv @@
module b2r_letters
   import b2r_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  b2r_digits_type  in_digits,
   output logic            out_valid,
   input  logic            out_ready,
   output b2r_letters_type out_letters
);

   logic            vld_ff, vld_in;
   b2r_letters_type let_ff, let_in;
   b2r_word_type    w_th, w_hu, w_te, w_un;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      w_th        = digit_word({2'b00, in_digits.th}, LTR_M, LTR_M, LTR_M);
      w_hu        = digit_word(in_digits.hu, LTR_C, LTR_D, LTR_M);
      w_te        = digit_word(in_digits.te, LTR_X, LTR_L, LTR_C);
      w_un        = digit_word(in_digits.un, LTR_I, LTR_V, LTR_X);
      let_in.hi   = cat_words(w_th, w_hu);
      let_in.lo   = cat_words(w_te, w_un);
      let_in.zero = in_digits.zero;
      let_in.oor  = in_digits.oor;
      vld_in      = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         let_ff <= let_in;
      end
   end

   assign out_valid   = vld_ff;
   assign out_letters = let_ff;

endmodule

@@ sv/b2r_serial.sv @@
module b2r_serial
   import b2r_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  b2r_letters_type in_letters,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_symbol,
   output logic            rsp_last,
   output logic            rsp_empty_res,
   output logic            rsp_out_of_range
);

   logic         vld_ff, vld_in;
   b2r_line_type line_ff, line_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         emp_ff, emp_in;
   logic         oor_ff, oor_in;
   logic         load;

   assign in_ready = !vld_ff || (rsp_ready && cnt_ff == 4'd1);
   assign load     = in_valid && in_ready;

   always_comb begin
      vld_in  = vld_ff;
      line_in = line_ff;
      cnt_in  = cnt_ff;
      emp_in  = emp_ff;
      oor_in  = oor_ff;
      if (vld_ff && rsp_ready) begin
         line_in[LINE_LEN-2:0] = line_ff[LINE_LEN-1:1];
         line_in[LINE_LEN-1]   = LTR_I;
         cnt_in                = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) vld_in = 1'b0;
      end
      if (load) begin
         vld_in  = 1'b1;
         line_in = cat_halves(in_letters.hi, in_letters.lo);
         emp_in  = in_letters.zero || in_letters.oor;
         oor_in  = in_letters.oor;
         cnt_in  = (in_letters.zero || in_letters.oor) ? 4'd1
                                                        : 4'(in_letters.hi.len + in_letters.lo.len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= 4'd0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      emp_ff  <= emp_in;
      oor_ff  <= oor_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_symbol       = emp_ff ? 8'h00 : letter_ascii(line_ff[0]);
   assign rsp_last         = cnt_ff == 4'd1;
   assign rsp_empty_res    = emp_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

@@ sv/binary_to_roman_numeral.sv @@
// Converts a 12-bit unsigned value into its Roman numeral, sent as ASCII letters one
// transaction per letter, most significant letter first, with rsp_last on the final one.
// A zero value gives a single empty transaction; a value above 3999 gives a single empty
// transaction flagged out of range. Digit extraction and letter assembly run in a
// four-stage pipeline ahead of the output serializer; an input passes the digit stages
// and the letter stage and is loaded into the serializer before its first letter is
// presented. Each input has one to fifteen letters, and the output serializer sends one
// letter per cycle while rsp_ready is high; the first letter of the next numeral follows
// the last letter of the previous one without a gap if the next is already waiting, and
// new inputs are accepted while earlier ones are still being sent.
module binary_to_roman_numeral
   import b2r_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_symbol,
   output logic        rsp_last,
   output logic        rsp_empty_res,
   output logic        rsp_out_of_range
);

   logic            dig_valid, dig_ready;
   b2r_digits_type  dig;
   logic            let_valid, let_ready;
   b2r_letters_type ltrs;

   b2r_digits u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_value   (req_value),
      .out_valid  (dig_valid),
      .out_ready  (dig_ready),
      .out_digits (dig)
   );

   b2r_letters u_letters (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dig_valid),
      .in_ready    (dig_ready),
      .in_digits   (dig),
      .out_valid   (let_valid),
      .out_ready   (let_ready),
      .out_letters (ltrs)
   );

   b2r_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (let_valid),
      .in_ready         (let_ready),
      .in_letters       (ltrs),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

@@ sv/b2r_checker.sv @@
`include "binary_to_roman_numeral_assert.svh"

module b2r_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_symbol,
   input logic        rsp_last,
   input logic        rsp_empty_res,
   input logic        rsp_out_of_range
);

   logic       empty_vld, oor_vld, letter_vld, take_mid, stall;
   logic       empty_ok, letter_ok, hold_ok;
   logic [8:0] held_ff;

   assign empty_vld  = rsp_valid && rsp_empty_res;
   assign oor_vld    = rsp_valid && rsp_out_of_range;
   assign letter_vld = rsp_valid && !rsp_empty_res;
   assign take_mid   = rsp_valid && rsp_ready && !rsp_last;
   assign stall      = rsp_valid && !rsp_ready;
   assign empty_ok   = rsp_symbol == 8'h00 && rsp_last;
   assign letter_ok  = rsp_symbol == 8'h49 || rsp_symbol == 8'h56 || rsp_symbol == 8'h58 ||
                       rsp_symbol == 8'h4C || rsp_symbol == 8'h43 || rsp_symbol == 8'h44 ||
                       rsp_symbol == 8'h4D;
   assign hold_ok    = rsp_valid && {rsp_symbol, rsp_last} == held_ff;

   always_ff @(posedge clock) begin
      held_ff <= {rsp_symbol, rsp_last};
   end

   `B2R_ASSERT_NOW(a_empty_single, clock, reset, empty_vld, empty_ok, "empty not lone")

   `B2R_ASSERT_NOW(a_oor_empty, clock, reset, oor_vld, rsp_empty_res, "out of range not empty")

   `B2R_ASSERT_NOW(a_letter_code, clock, reset, letter_vld, letter_ok, "invalid letter symbol")

   `B2R_ASSERT_NEXT(a_no_gap, clock, reset, take_mid, letter_vld, "gap inside a numeral")

   `B2R_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, hold_ok, "stalled result changed")

endmodule

bind binary_to_roman_numeral b2r_checker u_b2r_checker (.*);

@@ dv/binary_to_roman_numeral_tb.sv @@
`timescale 1ns / 100ps

module binary_to_roman_numeral_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [7:0] SYM_NONE = 8'h00;
   localparam logic [7:0] SYM_I = 8'h49;
   localparam logic [7:0] SYM_V = 8'h56;
   localparam logic [7:0] SYM_X = 8'h58;
   localparam logic [7:0] SYM_L = 8'h4C;
   localparam logic [7:0] SYM_C = 8'h43;
   localparam logic [7:0] SYM_D = 8'h44;
   localparam logic [7:0] SYM_M = 8'h4D;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic       empty_res;
      logic       out_of_range;
   } numeral_char_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [11:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_symbol;
   logic        rsp_last;
   logic        rsp_empty_res;
   logic        rsp_out_of_range;

   numeral_char_type expected_chars[$];
   logic [7:0]       spell_buf[16];
   int               spell_len;
   int               error_count;
   int               idle_cycles;
   int               hold_off_request;
   bit               tx_idle_on;
   bit               rx_idle_on;

   binary_to_roman_numeral u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void spell_digit(input int d, input logic [7:0] one,
                                       input logic [7:0] five, input logic [7:0] ten);
      int rest;
      rest = d;
      if (d == 9) begin
         spell_buf[spell_len++] = one;
         spell_buf[spell_len++] = ten;
      end else if (d == 4) begin
         spell_buf[spell_len++] = one;
         spell_buf[spell_len++] = five;
      end else begin
         if (rest >= 5) begin
            spell_buf[spell_len++] = five;
            rest -= 5;
         end
         for (int i = 0; i < rest; i++) spell_buf[spell_len++] = one;
      end
   endfunction

   function automatic void predict_numeral(input logic [11:0] value);
      numeral_char_type c;
      int v;
      v = int'(value);
      if (value > b2r_pkg::MAX_VALUE) begin
         c = '{SYM_NONE, 1'b1, 1'b1, 1'b1};
         expected_chars.push_back(c);
      end else if (v == 0) begin
         c = '{SYM_NONE, 1'b1, 1'b1, 1'b0};
         expected_chars.push_back(c);
      end else begin
         spell_len = 0;
         spell_digit((v / 1000) % 10, SYM_M, SYM_M, SYM_M);
         spell_digit((v / 100) % 10, SYM_C, SYM_D, SYM_M);
         spell_digit((v / 10) % 10, SYM_X, SYM_L, SYM_C);
         spell_digit(v % 10, SYM_I, SYM_V, SYM_X);
         for (int k = 0; k < spell_len; k++) begin
            c = '{spell_buf[k], (k == spell_len - 1), 1'b0, 1'b0};
            expected_chars.push_back(c);
         end
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_value(input logic [11:0] value);
      int gap;
      gap = tx_idle_on ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_numeral(value);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [11:0] values[$];
      values = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd6, 12'd9, 12'd10, 12'd40, 12'd49,
                 12'd90, 12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000,
                 12'd1994, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2730,
                 12'd1365, 12'd2048};
      foreach (values[i]) send_value(values[i]);
      wait_drained();
   endtask

   task automatic test_random_values(input int count);
      logic [11:0] v;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80) v = 12'($urandom_range(1, 3999));
         else if (r < 90) v = 12'($urandom_range(4000, 4095));
         else if (r < 95) v = 12'd0;
         else v = 12'($urandom_range(0, 4095));
         send_value(v);
      end
   endtask

   task automatic test_back_to_back(input int count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      for (int i = 0; i < count; i++) send_value(12'($urandom_range(0, 4095)));
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_output_hold_off(input int count);
      tx_idle_on = 1'b0;
      hold_off_request = 300;
      for (int i = 0; i < count; i++) send_value(12'($urandom_range(3000, 3999)));
      tx_idle_on = 1'b1;
   endtask

   task automatic test_drain_pause(input int count);
      for (int i = 0; i < count; i++) begin
         send_value(12'($urandom_range(0, 4095)));
         if (i % 8 == 7) wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      error_count = 0;
      hold_off_request = 0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_values(300);
      test_back_to_back(60);
      test_output_hold_off(40);
      test_drain_pause(40);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("binary_to_roman_numeral verification clean");
      end else begin
         $display("binary_to_roman_numeral verification failed");
      end
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = random_gap();
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      numeral_char_type got;
      numeral_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_symbol, rsp_last, rsp_empty_res, rsp_out_of_range};
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected transaction symbol=%h last=%b empty=%b oor=%b",
                     $time, got.symbol, got.last, got.empty_res, got.out_of_range);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (got.symbol !== want.symbol || got.last !== want.last ||
                got.empty_res !== want.empty_res || got.out_of_range !== want.out_of_range)
            begin
               $display("%0t: expected symbol=%h last=%b empty=%b oor=%b, %s",
                        $time, want.symbol, want.last, want.empty_res, want.out_of_range,
                        "see actual below");
               $display("%0t: actual symbol=%h last=%b empty=%b oor=%b",
                        $time, got.symbol, got.last, got.empty_res, got.out_of_range);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, expected_chars.size());
         $display("binary_to_roman_numeral verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial idle_cycles = 0;

endmodule
